/* sv/lef_pkg.sv */
// Shared types, register codes and the per-channel edge function for the Laplacian filter.
package lef_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef logic [7:0][7:0] nbr_t;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam logic [11:0] CHAN_MAX           = 12'd255;

    // 8*center minus neighbors, clipped to 0..255
    function automatic logic [7:0] edge_value(input logic [7:0] center, input nbr_t nbr);
        logic [10:0] sum;
        logic signed [11:0] acc;
        logic [7:0] res;
        sum = '0;
        for (int k = 0; k < 8; k++)
        begin
            sum = sum + 11'(nbr[k]);
        end
        acc = $signed({1'b0, center, 3'b000}) - $signed({1'b0, sum});
        if (acc < 0)
        begin
            res = 8'd0;
        end
        else if (acc > $signed(CHAN_MAX))
        begin
            res = 8'hFF;
        end
        else
        begin
            res = acc[7:0];
        end
        return res;
    endfunction

endpackage

/* sv/laplacian_edge_filter.sv */
// Top level: 3x3 Laplacian edge filter on an RGB raster stream with two line stores.
// An accepted request is held in the s1 registers, then passed to the output register when that is free.
// Throughput: one pixel per cycle while the output is not stalled; line stores are read at accept, written at s1_fire.
// Output register holds a result while it waits; input is taken then only while s1 is empty.
// Reset clears counters and valid flags and loads 640x480; line stores are not cleared.
module laplacian_edge_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  out_col,
    output logic [11:0] out_row,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        frame_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

    typedef struct packed {
        logic [CW-1:0] x;
        logic [9:0]    col;
        logic [11:0]   row;
        logic          calc;
        logic          done;
    } s1_ctrl_t;

    logic [10:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [11:0] row_count_reg, row_count_next;

    logic s1_valid_reg;
    s1_ctrl_t s1_reg, s1_next;
    lef_pkg::pixel_t s1_px_reg;
    lef_pkg::pixel_t top_reg, mid_reg;
    lef_pkg::pixel_t win_reg [6];

    logic [23:0] line_two_mem [MAX_WIDTH];
    logic [23:0] line_one_mem [MAX_WIDTH];

    logic out_valid_reg;
    logic [9:0] out_col_reg;
    logic [11:0] out_row_reg;
    lef_pkg::pixel_t out_px_reg, edge_px;
    logic out_done_reg;

    logic out_free, s1_fire, accept;
    logic [12:0] w13, col13, x13;
    logic [11:0] h12, row_t, y;
    logic cwrap;
    logic [CW-1:0] x;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lef_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= lef_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lef_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                lef_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    // position of this request and the result it emits
    always_comb
    begin
        if (frame_width_reg < 11'd3)
        begin
            w13 = 13'd3;
        end
        else if (13'(frame_width_reg) > MAXW)
        begin
            w13 = MAXW;
        end
        else
        begin
            w13 = 13'(frame_width_reg);
        end
        h12 = (frame_height_reg < 12'd3) ? 12'd3 : frame_height_reg;

        col13 = 13'(col_count_reg);
        cwrap = (col13 >= w13);
        x     = cwrap ? '0 : col_count_reg;
        x13   = 13'(x);
        row_t = cwrap ? row_count_reg + 12'd1 : row_count_reg;
        y     = (row_t >= h12) ? 12'd0 : row_t;

        s1_next.x    = x;
        s1_next.calc = 1'b0;
        if (y == 12'd0)
        begin
            s1_next.col = x13[9:0];
            s1_next.row = h12 - 12'd1;
        end
        else if (x13 == 13'd0)
        begin
            s1_next.col = 10'(w13 - 13'd1);
            s1_next.row = y - 12'd1;
        end
        else
        begin
            s1_next.col  = 10'(x13 - 13'd1);
            s1_next.row  = y - 12'd1;
            s1_next.calc = (x13 != 13'd1) && (y != 12'd1);
        end
        s1_next.done = (x13 == w13 - 13'd1) && (y == h12 - 12'd1);

        if (x13 == w13 - 13'd1)
        begin
            col_count_next = '0;
            row_count_next = (y == h12 - 12'd1) ? 12'd0 : y + 12'd1;
        end
        else
        begin
            col_count_next = x + CW'(1);
            row_count_next = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                s1_valid_reg  <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg    <= s1_next;
            s1_px_reg <= '{red: red_in, green: green_in, blue: blue_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            line_two_mem[s1_reg.x] <= mid_reg;
        end
        if (accept)
        begin
            top_reg <= line_two_mem[x];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            line_one_mem[s1_reg.x] <= s1_px_reg;
        end
        if (accept)
        begin
            mid_reg <= line_one_mem[x];
        end
    end

    // window rows y-2, y-1, y; columns x-2 (0..2) and x-1 (3..5)
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_reg;
            win_reg[4] <= mid_reg;
            win_reg[5] <= s1_px_reg;
        end
    end

    always_comb
    begin
        edge_px = '0;
        if (s1_reg.calc)
        begin
            edge_px.red = lef_pkg::edge_value(win_reg[4].red,
                {win_reg[0].red, win_reg[3].red, top_reg.red, win_reg[1].red,
                 mid_reg.red, win_reg[2].red, win_reg[5].red, s1_px_reg.red});
            edge_px.green = lef_pkg::edge_value(win_reg[4].green,
                {win_reg[0].green, win_reg[3].green, top_reg.green, win_reg[1].green,
                 mid_reg.green, win_reg[2].green, win_reg[5].green, s1_px_reg.green});
            edge_px.blue = lef_pkg::edge_value(win_reg[4].blue,
                {win_reg[0].blue, win_reg[3].blue, top_reg.blue, win_reg[1].blue,
                 mid_reg.blue, win_reg[2].blue, win_reg[5].blue, s1_px_reg.blue});
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_col_reg  <= s1_reg.col;
            out_row_reg  <= s1_reg.row;
            out_px_reg   <= edge_px;
            out_done_reg <= s1_reg.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign red_out    = out_px_reg.red;
    assign green_out  = out_px_reg.green;
    assign blue_out   = out_px_reg.blue;
    assign frame_done = out_done_reg;

endmodule

/* sv/lef_checker.sv */
// Port-level checks for the Laplacian filter and their bind to the top level.
module lef_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  out_col,
    input logic [11:0] out_row,
    input logic [7:0]  red_out,
    input logic [7:0]  green_out,
    input logic [7:0]  blue_out,
    input logic        frame_done
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row)
            && $stable(red_out) && $stable(green_out) && $stable(blue_out)
            && $stable(frame_done))
        else $error("result request changed while stalled");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result request dropped without handshake");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_col == 10'd0 || out_row == 12'd0)
            |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
        else $error("border pixel not zero");

    a_done_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> out_col != 10'd0 && out_row != 12'd0)
        else $error("frame end tagged on a border pixel");

endmodule

bind laplacian_edge_filter lef_checker u_lef_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the 3x3 Laplacian edge filter: raster frames in, results checked.
module tb;

    localparam int LINE_MAX    = 1024;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_ITEMS  = 900;
    localparam int PHASE_CAP   = 200;

    typedef logic [8:0][23:0] window_t;

    typedef struct {
        logic [9:0]       col;
        logic [11:0]      row;
        lef_pkg::pixel_t  px;
        logic             done;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        frame_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = lef_pkg::REG_FRAME_WIDTH;
    logic [11:0] cfg_data = '0;

    // filter model state
    lef_pkg::pixel_t line_two_up [LINE_MAX];
    lef_pkg::pixel_t line_one_up [LINE_MAX];
    lef_pkg::pixel_t win_cols [6];
    int              cur_col;
    int              cur_row;
    logic [10:0]     width_reg;
    logic [11:0]     height_reg;

    lef_pkg::pixel_t raster_q [$];
    result_t         filtered_q [$];
    int              px_pushed = 0;
    int              px_taken = 0;
    int              errors = 0;
    int              quiet = 0;
    int              send_wait = 0;
    int              send_calm = 0;
    int              stall_left = 0;
    int              ready_calm = 0;
    int              style = 0;
    lef_pkg::pixel_t smooth_base;
    lef_pkg::pixel_t drv_px;

    laplacian_edge_filter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_col    (out_col),
        .out_row    (out_row),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_done (frame_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 3)
        begin
            w = 3;
        end
        if (w > LINE_MAX)
        begin
            w = LINE_MAX;
        end
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(height_reg);
        if (h < 3)
        begin
            h = 3;
        end
        return h;
    endfunction

    // pixels left until the model is back at the first pixel of a frame
    function automatic int frame_left();
        int w;
        int h;
        int c;
        int r;
        w = eff_width();
        h = eff_height();
        c = cur_col;
        r = cur_row;
        if (c >= w)
        begin
            c = 0;
            r = r + 1;
        end
        if (r >= h)
        begin
            r = 0;
        end
        if (c == 0 && r == 0)
        begin
            return 0;
        end
        return (h - r) * w - c;
    endfunction

    function automatic logic [7:0] lap_value(input window_t win, input int sh);
        int acc;
        int v;
        acc = 8 * int'((win[4] >> sh) & 24'hFF);
        for (int k = 0; k < 9; k++)
        begin
            if (k != 4)
            begin
                v = int'((win[k] >> sh) & 24'hFF);
                acc = acc - v;
            end
        end
        if (acc > 255)
        begin
            acc = 255;
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        return 8'(acc);
    endfunction

    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 63) == 0)
        begin
            calm = $urandom_range(20, 150);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic filter_pixel(input lef_pkg::pixel_t p);
        int              w;
        int              h;
        int              x;
        int              y;
        lef_pkg::pixel_t top;
        lef_pkg::pixel_t mid;
        window_t         win;
        result_t         res;
        w = eff_width();
        h = eff_height();
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row = cur_row + 1;
        end
        if (cur_row >= h)
        begin
            cur_row = 0;
        end
        x = cur_col;
        y = cur_row;
        top = line_two_up[x];
        mid = line_one_up[x];
        res.px = '0;
        if (y == 0)
        begin
            res.col = 10'(x);
            res.row = 12'(h - 1);
        end
        else if (x == 0)
        begin
            res.col = 10'(w - 1);
            res.row = 12'(y - 1);
        end
        else
        begin
            res.col = 10'(x - 1);
            res.row = 12'(y - 1);
            if (x - 1 != 0 && y - 1 != 0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win[k * 3]     = win_cols[k];
                    win[k * 3 + 1] = win_cols[3 + k];
                end
                win[2] = top;
                win[5] = mid;
                win[8] = p;
                res.px.red   = lap_value(win, 16);
                res.px.green = lap_value(win, 8);
                res.px.blue  = lap_value(win, 0);
            end
        end
        res.done = (x == w - 1 && y == h - 1);
        filtered_q.push_back(res);
        for (int k = 0; k < 3; k++)
        begin
            win_cols[k] = win_cols[3 + k];
        end
        win_cols[3] = top;
        win_cols[4] = mid;
        win_cols[5] = p;
        line_two_up[x] = mid;
        line_one_up[x] = p;
        if (x == w - 1)
        begin
            cur_col = 0;
            cur_row = (y == h - 1) ? 0 : y + 1;
        end
        else
        begin
            cur_col = x + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors = errors + 1;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_wait > 0)
            begin
                in_valid <= 1'b0;
                send_wait = send_wait - 1;
            end
            else if (raster_q.size() != 0)
            begin
                drv_px = raster_q.pop_front();
                red_in   <= drv_px.red;
                green_in <= drv_px.green;
                blue_in  <= drv_px.blue;
                in_valid <= 1'b1;
                send_wait = next_gap(send_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = next_gap(ready_calm);
        end
    end

    // model update, result check, watchdog
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < LINE_MAX; k++)
            begin
                line_two_up[k] = '0;
                line_one_up[k] = '0;
            end
            for (int k = 0; k < 6; k++)
            begin
                win_cols[k] = '0;
            end
            cur_col = 0;
            cur_row = 0;
            width_reg = lef_pkg::FRAME_WIDTH_RESET;
            height_reg = lef_pkg::FRAME_HEIGHT_RESET;
            quiet = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lef_pkg::REG_FRAME_WIDTH)
                begin
                    width_reg = cfg_data[10:0];
                end
                else
                begin
                    height_reg = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                filter_pixel('{red: red_in, green: green_in, blue: blue_in});
                px_taken = px_taken + 1;
            end
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("unexpected result at col %0d row %0d", out_col, out_row);
                    errors = errors + 1;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    check_field("out_col", 12'(want.col), 12'(out_col));
                    check_field("out_row", want.row, out_row);
                    check_field("red_out", 12'(want.px.red), 12'(red_out));
                    check_field("green_out", 12'(want.px.green), 12'(green_out));
                    check_field("blue_out", 12'(want.px.blue), 12'(blue_out));
                    check_field("frame_done", 12'(want.done), 12'(frame_done));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet = quiet + 1;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    task automatic queue_px(input lef_pkg::pixel_t p);
        raster_q.push_back(p);
        px_pushed = px_pushed + 1;
    endtask

    function automatic logic [7:0] rand_chan(input logic [7:0] base);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = int'(base) + $urandom_range(0, 12) - 6;
            default: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
        endcase
        return 8'(v);
    endfunction

    task automatic queue_random(input int n);
        lef_pkg::pixel_t p;
        for (int k = 0; k < n; k++)
        begin
            p.red   = rand_chan(smooth_base.red);
            p.green = rand_chan(smooth_base.green);
            p.blue  = rand_chan(smooth_base.blue);
            queue_px(p);
        end
    endtask

    // all requests taken and all results back, then let the pipeline drain
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (px_taken != px_pushed || filtered_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    task automatic release_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_frame3(input lef_pkg::pixel_t center, input lef_pkg::pixel_t nbr);
        for (int k = 0; k < 9; k++)
        begin
            queue_px((k == 4) ? center : nbr);
        end
    endtask

    initial
    begin : stimulus
        int    rand_items;
        int    n;
        int    left;
        int    w_cap;
        logic [11:0] wdata;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few pixels at the reset geometry
        queue_px('{red: 8'h00, green: 8'h00, blue: 8'h00});
        queue_px('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        queue_px('{red: 8'hAA, green: 8'h55, blue: 8'hAA});
        wait_idle();

        // narrow mid-line: column wraps and row advances
        write_reg(lef_pkg::REG_FRAME_WIDTH, 12'd3);
        write_reg(lef_pkg::REG_FRAME_HEIGHT, 12'd3);
        release_cfg();
        style = 0;
        queue_random(frame_left());
        wait_idle();

        // saturation high, low and in range on one filtered center
        queue_frame3('{red: 8'd255, green: 8'd0, blue: 8'd200},
                     '{red: 8'd0, green: 8'd255, blue: 8'd190});
        wait_idle();

        // out-of-range sizes clamp to the minimum
        write_reg(lef_pkg::REG_FRAME_WIDTH, 12'd2);
        write_reg(lef_pkg::REG_FRAME_HEIGHT, 12'd0);
        release_cfg();
        queue_frame3('{red: 8'd0, green: 8'd255, blue: 8'd32},
                     '{red: 8'd255, green: 8'd0, blue: 8'd0});
        wait_idle();

        // widest line, tallest frame: last-row and line-start coordinates
        write_reg(lef_pkg::REG_FRAME_WIDTH, 12'd2047);
        write_reg(lef_pkg::REG_FRAME_HEIGHT, 12'd4095);
        release_cfg();
        queue_random(3);
        wait_idle();
        write_reg(lef_pkg::REG_FRAME_WIDTH, 12'd3);
        release_cfg();
        queue_random(3);
        wait_idle();
        write_reg(lef_pkg::REG_FRAME_WIDTH, 12'd2047);
        release_cfg();
        queue_random(2);
        wait_idle();
        write_reg(lef_pkg::REG_FRAME_WIDTH, 12'd3);
        write_reg(lef_pkg::REG_FRAME_HEIGHT, 12'd3);
        release_cfg();
        queue_random(frame_left());
        wait_idle();

        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                if (cur_col == 0 && cur_row == 0)
                begin
                    n = $urandom_range(0, 99);
                    if (n < 80)
                    begin
                        wdata = 12'($urandom_range(3, 12));
                    end
                    else if (n < 88)
                    begin
                        wdata = 12'($urandom_range(13, 40));
                    end
                    else if (n < 92)
                    begin
                        wdata = 12'd1024;
                    end
                    else if (n < 96)
                    begin
                        wdata = 12'($urandom_range(0, 2));
                    end
                    else
                    begin
                        wdata = 12'($urandom_range(1025, 4095));
                    end
                end
                else
                begin
                    // mid-frame the line may only shrink
                    w_cap = eff_width();
                    wdata = 12'($urandom_range(0, w_cap));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        wdata[11] = 1'b1;
                    end
                end
                write_reg(lef_pkg::REG_FRAME_WIDTH, wdata);
            end
            if ($urandom_range(0, 1) != 0)
            begin
                n = $urandom_range(0, 99);
                if (n < 75)
                begin
                    wdata = 12'($urandom_range(3, 8));
                end
                else if (n < 85)
                begin
                    wdata = 12'($urandom_range(9, 30));
                end
                else if (n < 90)
                begin
                    wdata = 12'd4095;
                end
                else if (n < 95)
                begin
                    wdata = 12'($urandom_range(0, 2));
                end
                else
                begin
                    wdata = 12'($urandom_range(31, 4094));
                end
                write_reg(lef_pkg::REG_FRAME_HEIGHT, wdata);
            end
            release_cfg();

            style = $urandom_range(0, 2);
            smooth_base.red   = 8'($urandom_range(8, 247));
            smooth_base.green = 8'($urandom_range(8, 247));
            smooth_base.blue  = 8'($urandom_range(8, 247));
            left = frame_left();
            if (left == 0)
            begin
                left = eff_width() * eff_height();
            end
            if (left <= PHASE_CAP && $urandom_range(0, 3) != 0)
            begin
                n = left;
            end
            else
            begin
                n = $urandom_range(1, (left < 40) ? left : 40);
            end
            queue_random(n);
            rand_items = rand_items + n;
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
